@@ rtl/fxalu_pkg.sv @@
// Shared opcode type and default sizes for the Q24.8 fixed-point ALU.
package fxalu_pkg;

  // Default word format: 32-bit raw words with eight fraction bits.
  localparam int DefWordBits = 32;
  localparam int DefFracBits = 8;

  // Operation codes carried on the input tuser field.
  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_GT  = 4'd4,
    OP_LT  = 4'd5,
    OP_GE  = 4'd6,
    OP_LE  = 4'd7,
    OP_EQ  = 4'd8,
    OP_NE  = 4'd9,
    OP_MIN = 4'd10,
    OP_MAX = 4'd11,
    OP_INC = 4'd12,
    OP_DEC = 4'd13
  } op_t;

endpackage

@@ rtl/fxalu_div_step.sv @@
// One restoring-division step: shifts in a numerator bit and yields one quotient bit.
module fxalu_div_step #(
  parameter int WORD_BITS = fxalu_pkg::DefWordBits,
  parameter int NUM_BITS  = fxalu_pkg::DefWordBits + fxalu_pkg::DefFracBits
) (
  input  logic [NUM_BITS-1:0]  num_i,
  input  logic [WORD_BITS:0]   rem_i,
  input  logic [NUM_BITS-1:0]  quo_i,
  input  logic [WORD_BITS-1:0] divisor_i,
  output logic [NUM_BITS-1:0]  num_o,
  output logic [WORD_BITS:0]   rem_o,
  output logic [NUM_BITS-1:0]  quo_o
);
  import fxalu_pkg::*;

  logic [WORD_BITS:0] trial;
  logic               fits;

  // Bring down the next numerator bit and try a subtraction.
  always_comb begin
    trial = {rem_i[WORD_BITS-1:0], num_i[NUM_BITS-1]};
    fits  = (trial >= {1'b0, divisor_i});
    num_o = {num_i[NUM_BITS-2:0], 1'b0};
    rem_o = fits ? (trial - {1'b0, divisor_i}) : trial;
    quo_o = {quo_i[NUM_BITS-2:0], fits};
  end

endmodule

@@ rtl/fixed_point_q24_8_alu.sv @@
// Top level of the pipelined saturating fixed-point ALU.
//
//  Channel | Ports                        | Contents
//  --------+------------------------------+----------------------------------------
//  input   | in_tvalid/in_tready          | tuser: opcode; tdata: operand_a, b
//  result  | out_tvalid/out_tready        | tuser: flags; tdata: result_value
//
// Every operation passes the same pipeline of WORD_BITS+FRAC_BITS+2 register stages;
// the depth is set by the divider, which retires one quotient bit per stage. One
// transaction is accepted per cycle unless back-pressure stalls the pipeline.
// Reset clears only the stage valid bits. A stalled result holds the last stage;
// earlier stages keep filling empty slots, so bubbles collapse under back-pressure.
module fixed_point_q24_8_alu #(
  parameter int WORD_BITS = fxalu_pkg::DefWordBits,
  parameter int FRAC_BITS = fxalu_pkg::DefFracBits
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // opcode in [3:0]
  input  logic [3:0]                             in_tuser,
  // operand_a, then operand_b, zero padding to whole bytes
  input  logic [((2*WORD_BITS+7)/8)*8-1:0]       in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // compare_true, saturated, divide_by_zero from bit 0 up
  output logic [2:0]                             out_tuser,
  // result_value, zero padding to whole bytes
  output logic [((WORD_BITS+7)/8)*8-1:0]         out_tdata
);
  import fxalu_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int NB  = W + F;
  localparam int NST = NB + 2;
  localparam int ODW = ((W + 7) / 8) * 8;
  localparam logic [W-1:0]   WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]   WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [2*W:0]   HALF = (2*W+1)'(1) << (F - 1);

  typedef struct packed {
    op_t            op;
    logic [W-1:0]   a;
    logic [W-1:0]   b;
    logic [W-1:0]   val;
    logic           cmp;
    logic           sat;
    logic           dz;
    logic           neg;
    logic [W-1:0]   mb;
    logic [NB-1:0]  num;
    logic [W:0]     rem;
    logic [NB-1:0]  quo;
    logic [2*W-1:0] prod;
  } item_t;

  item_t st_r   [NST];
  item_t st_nxt [NST];
  logic  vld_r  [NST];
  logic  en     [NST];

  // Two's-complement magnitude; the most negative word maps to 2^(W-1).
  function automatic logic [W-1:0] mag_f(input logic [W-1:0] x);
    return x[W-1] ? (~x + 1'b1) : x;
  endfunction

  // Clamp a signed magnitude to the word range: returns {saturated, value}.
  function automatic logic [W:0] pack_f(input logic neg, input logic [2*W:0] m);
    logic [2*W:0] lim;
    lim = {{(W+1){1'b0}}, WMAX};
    if (neg) lim = lim + 1'b1;
    if (m > lim) return {1'b1, neg ? WMIN : WMAX};
    return {1'b0, neg ? (~m[W-1:0] + 1'b1) : m[W-1:0]};
  endfunction

  // Stall chain: a stage may load when it is empty or its successor moves.
  always_comb begin
    en[NST-1] = !vld_r[NST-1] || out_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  // Entry stage: unpack operands, signs and division setup.
  logic [W-1:0] in_a, in_b;
  assign in_a = in_tdata[W-1:0];
  assign in_b = in_tdata[2*W-1:W];

  always_comb begin
    st_nxt[0]      = '0;
    st_nxt[0].op   = op_t'(in_tuser);
    st_nxt[0].a    = in_a;
    st_nxt[0].b    = in_b;
    st_nxt[0].neg  = in_a[W-1] ^ in_b[W-1];
    st_nxt[0].mb   = mag_f(in_b);
    st_nxt[0].num  = {mag_f(in_a), {F{1'b0}}};
  end

  // Stage one: add, subtract, compare, min/max, divide-by-zero, magnitude product.
  logic [W-1:0]   s1_opb, s1_add, s1_sub, s1_val;
  logic           s1_lt, s1_eq, s1_cmp, s1_sat, s1_dz, s1_aovf, s1_sovf;
  logic [2*W-1:0] s1_prod;

  always_comb begin
    s1_opb  = (st_r[0].op == OP_INC || st_r[0].op == OP_DEC) ? W'(1) : st_r[0].b;
    s1_add  = st_r[0].a + s1_opb;
    s1_sub  = st_r[0].a - s1_opb;
    s1_aovf = (st_r[0].a[W-1] == s1_opb[W-1]) && (s1_add[W-1] != st_r[0].a[W-1]);
    s1_sovf = (st_r[0].a[W-1] != s1_opb[W-1]) && (s1_sub[W-1] != st_r[0].a[W-1]);
    s1_lt   = $signed(st_r[0].a) < $signed(st_r[0].b);
    s1_eq   = st_r[0].a == st_r[0].b;
    s1_prod = (2*W)'(mag_f(st_r[0].a)) * (2*W)'(mag_f(st_r[0].b));
    s1_val  = '0;
    s1_cmp  = 1'b0;
    s1_sat  = 1'b0;
    s1_dz   = 1'b0;
    case (st_r[0].op)
      OP_ADD, OP_INC: begin
        s1_sat = s1_aovf;
        s1_val = s1_aovf ? (st_r[0].a[W-1] ? WMIN : WMAX) : s1_add;
      end
      OP_SUB, OP_DEC: begin
        s1_sat = s1_sovf;
        s1_val = s1_sovf ? (st_r[0].a[W-1] ? WMIN : WMAX) : s1_sub;
      end
      OP_DIV: begin
        s1_dz  = (st_r[0].b == '0);
        s1_sat = s1_dz;
        s1_val = st_r[0].a[W-1] ? WMIN : WMAX;
      end
      OP_GT:  s1_cmp = !s1_lt && !s1_eq;
      OP_LT:  s1_cmp = s1_lt;
      OP_GE:  s1_cmp = !s1_lt;
      OP_LE:  s1_cmp = s1_lt || s1_eq;
      OP_EQ:  s1_cmp = s1_eq;
      OP_NE:  s1_cmp = !s1_eq;
      OP_MIN: s1_val = s1_lt ? st_r[0].a : st_r[0].b;
      OP_MAX: s1_val = (!s1_lt && !s1_eq) ? st_r[0].a : st_r[0].b;
      default: ;
    endcase
  end

  // Stage two: round the product half away from zero and clamp it.
  logic [2*W:0] s2_round;
  logic [W:0]   s2_pack;

  always_comb begin
    s2_round = ({1'b0, st_r[1].prod} + HALF) >> F;
    s2_pack  = pack_f(st_r[1].neg, s2_round);
  end

  // Last stage: round the quotient on the final remainder and clamp it.
  logic         fin_up;
  logic [2*W:0] fin_quo;
  logic [W:0]   fin_pack;

  always_comb begin
    fin_up   = {st_r[NST-2].rem, 1'b0} >= {2'b00, st_r[NST-2].mb};
    fin_quo  = (2*W+1)'(st_r[NST-2].quo) + (2*W+1)'(fin_up);
    fin_pack = pack_f(st_r[NST-2].neg, fin_quo);
  end

  // Division stages, one quotient bit each, carrying all other operations along.
  for (genvar k = 1; k < NST; k++) begin : g_st
    if (k < NST - 1) begin : g_div
      logic [NB-1:0] dnum, dquo;
      logic [W:0]    drem;

      fxalu_div_step #(.WORD_BITS(W), .NUM_BITS(NB)) u_step (
        .num_i     (st_r[k-1].num),
        .rem_i     (st_r[k-1].rem),
        .quo_i     (st_r[k-1].quo),
        .divisor_i (st_r[k-1].mb),
        .num_o     (dnum),
        .rem_o     (drem),
        .quo_o     (dquo)
      );

      always_comb begin
        st_nxt[k]     = st_r[k-1];
        st_nxt[k].num = dnum;
        st_nxt[k].rem = drem;
        st_nxt[k].quo = dquo;
        if (k == 1) begin
          st_nxt[k].val  = s1_val;
          st_nxt[k].cmp  = s1_cmp;
          st_nxt[k].sat  = s1_sat;
          st_nxt[k].dz   = s1_dz;
          st_nxt[k].prod = s1_prod;
        end
        if (k == 2 && st_r[k-1].op == OP_MUL) begin
          st_nxt[k].val = s2_pack[W-1:0];
          st_nxt[k].sat = s2_pack[W];
        end
      end
    end else begin : g_fin
      always_comb begin
        st_nxt[k] = st_r[k-1];
        if (st_r[k-1].op == OP_DIV && !st_r[k-1].dz) begin
          st_nxt[k].val = fin_pack[W-1:0];
          st_nxt[k].sat = fin_pack[W];
        end
      end
    end
  end

  // Stage registers with their valid bits.
  for (genvar k = 0; k < NST; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en[k]) begin
        vld_r[k] <= (k == 0) ? in_tvalid : vld_r[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // Result channel.
  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = ODW'(st_r[NST-1].val);
  assign out_tuser  = {st_r[NST-1].dz, st_r[NST-1].sat, st_r[NST-1].cmp};

  // A division by zero always reports a clamped result.
  a_dz_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1])
    else $error("divide-by-zero result without saturation flag");

  // A true comparison outcome comes with a zero value and no saturation flag.
  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata == '0) && !out_tuser[1])
    else $error("comparison result carries a value or saturation");

  // With the result side ready the whole pipeline advances.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while the result side is ready");

  // A result that was not taken stays in the last stage.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("pending result lost or changed");

endmodule
